// ----- sv/uart_ring_buffer_engine_core_macros.svh -----
// Assertion helpers used by the engine core RTL.
`ifndef UART_RING_BUFFER_ENGINE_CORE_MACROS_SVH
`define UART_RING_BUFFER_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define URBE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define URBE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/urbe_pkg.sv -----
package urbe_pkg;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_DRAIN = 3'd1,
    OP_RECV  = 3'd2,
    OP_READ  = 3'd3,
    OP_PEEK  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CFG_RX_LENGTH = 2'd0,
    CFG_TX_LENGTH = 2'd1
  } cfg_index_t;

  localparam int LEN_CAP = 64;
  localparam logic [6:0] LEN_MIN = 7'd2;
  localparam logic [6:0] LEN_RESET = 7'd64;

endpackage

// ----- sv/urbe_ram.sv -----
module urbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/uart_ring_buffer_engine_core.sv -----
// Serial port ring buffer engine.
// Input channel (in_valid/in_stall) carries one event: write byte, data
// register empty, byte received, read or peek. A transfer happens when
// in_valid is high and in_stall is low.
// Output channel (out_valid/out_stall) returns exactly one result per event:
// the byte for the data register, the byte read, ring status and flags.
// The transfer is registered into exec and the result from exec into the
// output register; no event is taken while one executes. The tail entry
// is read from the ring RAM in the transfer cycle (registered read) and
// the read-modify-write of pointers and ring happens in the following cycle.
// A finished result waits in the output register while out_stall is high;
// one further event may be taken meanwhile only after the register drains,
// so in_stall is high while executing or while a stalled result is held.
// Config channel (cfg_valid/cfg_ready, always ready) writes rx_length
// (index 0) or tx_length (index 1); a write empties that ring. Write only
// while idle. Reset empties both rings, clears the interrupt enable and
// sets both lengths to 64. Ring RAM contents are not cleared.
module uart_ring_buffer_engine_core
  import urbe_pkg::*;
#(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] operation,
  input  logic [7:0] data_byte,
  input  logic       register_free,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       line_valid,
  output logic [7:0] line_byte,
  output logic       read_valid,
  output logic [7:0] read_byte,
  output logic [5:0] rx_count,
  output logic [5:0] tx_free,
  output logic       tx_irq_on,
  output logic       write_refused,
  output logic       rx_dropped,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int RxTop = (RX_DEPTH < LEN_CAP) ? RX_DEPTH : LEN_CAP;
  localparam int TxTop = (TX_DEPTH < LEN_CAP) ? TX_DEPTH : LEN_CAP;
  localparam int RxPw = $clog2(RxTop);
  localparam int TxPw = $clog2(TxTop);
  localparam int RxAw = $clog2(RX_DEPTH);
  localparam int TxAw = $clog2(TX_DEPTH);

  function automatic logic [6:0] eff_len(input logic [6:0] r, input logic [6:0] top);
    logic [6:0] v;
    v = r;
    if (r < LEN_MIN) v = LEN_MIN;
    else if (r > top) v = top;
    return v;
  endfunction

  function automatic logic [6:0] wrap_inc(input logic [6:0] p, input logic [6:0] len);
    logic [6:0] n;
    n = p + 7'd1;
    return (n >= len) ? 7'd0 : n;
  endfunction

  logic [6:0] rx_length, tx_length;
  logic [RxPw-1:0] rx_head, rx_tail, rx_head_next, rx_tail_next;
  logic [TxPw-1:0] tx_head, tx_tail, tx_head_next, tx_tail_next;
  logic tx_irq_enable, tx_irq_enable_next;
  logic exec;
  op_t op_q;
  logic [7:0] byte_q;
  logic free_q;

  logic accept, cfg_we;
  logic [7:0] rx_rdata, tx_rdata;
  logic rx_we, tx_we;
  logic [6:0] rl, tl, nxt;
  logic lv, rv, refused, dropped;
  logic [7:0] lb, rb;
  logic [6:0] rxh7, rxt7, txh7, txt7, rxc, txf;

  assign accept = in_valid && !in_stall;
  assign in_stall = exec || (out_valid && out_stall);
  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;
  assign rl = eff_len(rx_length, 7'(RxTop));
  assign tl = eff_len(tx_length, 7'(TxTop));

  urbe_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk  (clk),
    .we   (rx_we),
    .waddr(RxAw'(rx_head)),
    .wdata(byte_q),
    .raddr(RxAw'(rx_tail)),
    .rdata(rx_rdata)
  );

  urbe_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk  (clk),
    .we   (tx_we),
    .waddr(TxAw'(tx_head)),
    .wdata(byte_q),
    .raddr(TxAw'(tx_tail)),
    .rdata(tx_rdata)
  );

  always_comb begin
    rx_head_next = rx_head;
    rx_tail_next = rx_tail;
    tx_head_next = tx_head;
    tx_tail_next = tx_tail;
    tx_irq_enable_next = tx_irq_enable;
    rx_we = 1'b0;
    tx_we = 1'b0;
    lv = 1'b0;
    lb = 8'd0;
    rv = 1'b0;
    rb = 8'd0;
    refused = 1'b0;
    dropped = 1'b0;
    nxt = 7'd0;
    if (exec) begin
      case (op_q)
        OP_WRITE: begin
          if (tx_head == tx_tail && free_q) begin
            lv = 1'b1;
            lb = byte_q;
          end else begin
            nxt = wrap_inc(7'(tx_head), tl);
            if (nxt == 7'(tx_tail)) begin
              refused = 1'b1;
            end else begin
              tx_we = 1'b1;
              tx_head_next = TxPw'(nxt);
              tx_irq_enable_next = 1'b1;
            end
          end
        end
        OP_DRAIN: begin
          if (tx_head != tx_tail) begin
            lv = 1'b1;
            lb = tx_rdata;
            tx_tail_next = TxPw'(wrap_inc(7'(tx_tail), tl));
          end
          if (tx_head == tx_tail_next) tx_irq_enable_next = 1'b0;
        end
        OP_RECV: begin
          nxt = wrap_inc(7'(rx_head), rl);
          if (nxt == 7'(rx_tail)) begin
            dropped = 1'b1;
          end else begin
            rx_we = 1'b1;
            rx_head_next = RxPw'(nxt);
          end
        end
        OP_READ, OP_PEEK: begin
          if (rx_head != rx_tail) begin
            rv = 1'b1;
            rb = rx_rdata;
            if (op_q == OP_READ) rx_tail_next = RxPw'(wrap_inc(7'(rx_tail), rl));
          end
        end
        default: begin
        end
      endcase
    end
    rxh7 = 7'(rx_head_next);
    rxt7 = 7'(rx_tail_next);
    txh7 = 7'(tx_head_next);
    txt7 = 7'(tx_tail_next);
    rxc = (rxh7 >= rxt7) ? (rxh7 - rxt7) : (rl + rxh7 - rxt7);
    txf = (txh7 >= txt7) ? (tl - 7'd1 - txh7 + txt7) : (txt7 - txh7 - 7'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exec <= 1'b0;
      out_valid <= 1'b0;
      rx_head <= '0;
      rx_tail <= '0;
      tx_head <= '0;
      tx_tail <= '0;
      tx_irq_enable <= 1'b0;
      rx_length <= LEN_RESET;
      tx_length <= LEN_RESET;
    end else begin
      exec <= accept;
      if (accept) begin
        op_q <= op_t'(operation);
        byte_q <= data_byte;
        free_q <= register_free;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (exec) begin
        out_valid <= 1'b1;
        line_valid <= lv;
        line_byte <= lb;
        read_valid <= rv;
        read_byte <= rb;
        rx_count <= rxc[5:0];
        tx_free <= txf[5:0];
        tx_irq_on <= tx_irq_enable_next;
        write_refused <= refused;
        rx_dropped <= dropped;
        rx_head <= rx_head_next;
        rx_tail <= rx_tail_next;
        tx_head <= tx_head_next;
        tx_tail <= tx_tail_next;
        tx_irq_enable <= tx_irq_enable_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RX_LENGTH: begin
            rx_length <= cfg_data;
            rx_head <= '0;
            rx_tail <= '0;
          end
          CFG_TX_LENGTH: begin
            tx_length <= cfg_data;
            tx_head <= '0;
            tx_tail <= '0;
            tx_irq_enable <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

`include "uart_ring_buffer_engine_core_macros.svh"

  `URBE_ASSERT_NEXT(a_accept_exec, accept, exec, "transfer not followed by execute")
  `URBE_ASSERT_NOW(a_out_free, exec, !out_valid, "result register busy at execute")
  `URBE_ASSERT_NOW(a_irq_nonempty, tx_irq_enable, tx_head != tx_tail, "irq on with empty ring")
  `URBE_ASSERT_NOW(a_rx_ptr_range, 1'b1, (7'(rx_head) < rl) && (7'(rx_tail) < rl),
                   "rx pointer beyond length")
  `URBE_ASSERT_NEXT(a_ptr_hold, !exec && !cfg_we,
                    $stable(rx_head) && $stable(tx_head) && $stable(tx_tail),
                    "pointer moved while idle")

endmodule
